@@ rtl/assert_macros.svh @@
// assertion macros used by energy_histogram_binner
// no dependencies; the including module provides i_clk and i_rst_n
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on the rising clock edge outside reset
`define CHK_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication, checked on the rising clock edge outside reset
`define CHK_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

@@ rtl/ebin_pkg.sv @@
// types and constants for the energy histogram binner
// no dependencies
`default_nettype none

package ebin_pkg;

    localparam int OFFSET_W  = 21;
    localparam int GAIN_W    = 32;
    localparam int COUNT_W   = 13;
    localparam int FUNC_W    = 2;
    localparam int ENERGY_W  = 20;
    localparam int WEIGHT_W  = 16;
    localparam int INDEX_W   = 12;
    localparam int CHAN_W    = 12;
    localparam int BIN_W     = 48;
    localparam int FRAC_BITS = 24;

    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 4;
    localparam int REG_SEL_W  = 2;

    localparam int DEF_MAX_CHANNELS = 4096;

    // difference of energy and offset, and its product with the gain
    localparam int DIFF_W = ENERGY_W + 2;
    localparam int PROD_W = DIFF_W + GAIN_W + 1;

    localparam logic [OFFSET_W-1:0] OFFSET_RST = '0;
    localparam logic [GAIN_W-1:0]   GAIN_RST   = 32'd16777216;
    localparam logic [COUNT_W-1:0]  COUNT_RST  = 13'd4096;

    // one half in the Q.24 product, for round half up
    localparam logic [PROD_W-1:0] HALF_Q = PROD_W'(1) << (FRAC_BITS - 1);

    localparam logic [BIN_W-1:0] BIN_MAX = '1;

    typedef enum logic [REG_SEL_W-1:0] {
        REG_OFFSET = 2'd0,
        REG_GAIN   = 2'd1,
        REG_COUNT  = 2'd2
    } t_reg_sel;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_ADD  = 2'd0,
        FUNC_READ = 2'd1,
        FUNC_RCLR = 2'd2
    } t_func;

endpackage

`default_nettype wire

@@ rtl/energy_histogram_binner.sv @@
// multichannel-analyzer histogram: channel mapping, bin store and apb registers
// depends on ebin_pkg and assert_macros.svh
//
// After reset the block sweeps the bin store to zero, one bin per cycle, while
// busy is high; start is ignored during the sweep.
// The energy-offset multiply by the gain is done straight from the
// command ports in the cycle the beat is accepted. After the accepting edge an
// item passes through S_MAP, for rounding, range check and the bin store read,
// and then S_MOD, for the add (or clear) and write back; its result is
// registered onto the ports at the end of S_MOD. The bin store read is
// registered. A new item is taken in the same cycle the previous result is
// shown on o_valid, so the block takes no new item while one is in flight.
// Results are presented for one cycle only; the receiver has no way to stall
// them.
`default_nettype none

`include "assert_macros.svh"

module energy_histogram_binner #(
    parameter int MAX_CHANNELS = ebin_pkg::DEF_MAX_CHANNELS
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // command channel
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic [ebin_pkg::FUNC_W-1:0]       i_func,
    input  wire logic [ebin_pkg::ENERGY_W-1:0]     i_energy,
    input  wire logic [ebin_pkg::WEIGHT_W-1:0]     i_weight,
    input  wire logic [ebin_pkg::INDEX_W-1:0]      i_bin_index,
    // result channel
    output logic                                   o_valid,
    output logic                                   o_status,
    output logic [ebin_pkg::CHAN_W-1:0]            o_channel,
    output logic [ebin_pkg::BIN_W-1:0]             o_bin_value,
    // register port
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [ebin_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [ebin_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [ebin_pkg::APB_DATA_W-1:0]        prdata,
    output logic                                   pready
);

    localparam int AW = $clog2(MAX_CHANNELS);
    localparam int CH_W = ebin_pkg::PROD_W - ebin_pkg::FRAC_BITS;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MAP,
        S_MOD
    } t_state;

    t_state r_state, n_state;

    // configuration
    logic [ebin_pkg::OFFSET_W-1:0] r_offset;
    logic [ebin_pkg::GAIN_W-1:0]   r_gain;
    logic [ebin_pkg::COUNT_W-1:0]  r_count;

    // item in flight
    logic [ebin_pkg::FUNC_W-1:0]      r_func;
    logic [ebin_pkg::WEIGHT_W-1:0]    r_weight;
    logic [ebin_pkg::INDEX_W-1:0]     r_index;
    logic signed [ebin_pkg::PROD_W-1:0] r_prod, n_prod;
    logic                             r_ok, n_ok;
    logic [ebin_pkg::CHAN_W-1:0]      r_chan, n_chan;
    logic [AW-1:0]                    r_addr, n_addr;
    logic [AW-1:0]                    r_clr_addr;

    // bin store
    logic [ebin_pkg::BIN_W-1:0] mem [MAX_CHANNELS];
    logic [ebin_pkg::BIN_W-1:0] r_rdata;
    logic                       mem_we;
    logic [AW-1:0]              mem_waddr;
    logic [ebin_pkg::BIN_W-1:0] mem_wdata;

    logic accept;
    logic cfg_write;
    logic signed [ebin_pkg::DIFF_W-1:0] diff;
    logic signed [ebin_pkg::PROD_W-1:0] rounded;
    logic [CH_W-1:0]                    ch_full;
    logic [31:0]                        eff_count;
    logic [ebin_pkg::BIN_W:0]           sum;
    logic [ebin_pkg::BIN_W-1:0]         sum_sat;
    logic [ebin_pkg::BIN_W-1:0]         n_value;

    assign busy      = (r_state != S_IDLE);
    assign accept    = start && !busy;
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    assign eff_count = (32'(r_count) < 32'(MAX_CHANNELS)) ? 32'(r_count)
                                                         : 32'(MAX_CHANNELS);

    always_comb begin
        case (paddr[ebin_pkg::APB_ADDR_W-1:2])
            ebin_pkg::REG_OFFSET: prdata = 32'($signed(r_offset));
            ebin_pkg::REG_GAIN:   prdata = r_gain;
            ebin_pkg::REG_COUNT:  prdata = 32'(r_count);
            default:              prdata = '0;
        endcase
    end

    // multiply stage, fed straight from the command ports
    always_comb begin
        diff   = $signed({2'b00, i_energy}) - $signed({r_offset[ebin_pkg::OFFSET_W-1], r_offset});
        n_prod = ebin_pkg::PROD_W'(diff) * ebin_pkg::PROD_W'($signed({1'b0, r_gain}));
    end

    // round, range check and bin address
    always_comb begin
        rounded = r_prod + $signed(ebin_pkg::HALF_Q);
        ch_full = rounded[ebin_pkg::PROD_W-1:ebin_pkg::FRAC_BITS];
        n_ok    = 1'b0;
        n_chan  = '0;
        n_addr  = '0;
        case (r_func)
            ebin_pkg::FUNC_ADD: begin
                if (!rounded[ebin_pkg::PROD_W-1] && (32'(ch_full) < eff_count)) begin
                    n_ok   = 1'b1;
                    n_chan = ch_full[ebin_pkg::CHAN_W-1:0];
                    n_addr = ch_full[AW-1:0];
                end
            end
            ebin_pkg::FUNC_READ, ebin_pkg::FUNC_RCLR: begin
                n_chan = r_index;
                n_addr = AW'(r_index);
                n_ok   = (32'(r_index) < eff_count);
            end
            default: begin
                n_ok = 1'b0;
            end
        endcase
    end

    // modify and write back, and the reset sweep writes; items never overlap, so no forwarding is needed
    always_comb begin
        sum     = {1'b0, r_rdata} + (ebin_pkg::BIN_W + 1)'(r_weight);
        sum_sat = sum[ebin_pkg::BIN_W] ? ebin_pkg::BIN_MAX : sum[ebin_pkg::BIN_W-1:0];
        n_value = '0;
        mem_wdata = '0;
        mem_we    = 1'b0;
        mem_waddr = r_clr_addr;
        if (r_state == S_CLEAR) begin
            mem_we = 1'b1;
        end else if (r_state == S_MOD && r_ok) begin
            case (r_func)
                ebin_pkg::FUNC_ADD: begin
                    mem_we    = 1'b1;
                    mem_waddr = r_addr;
                    mem_wdata = sum_sat;
                    n_value   = sum_sat;
                end
                ebin_pkg::FUNC_RCLR: begin
                    mem_we    = 1'b1;
                    mem_waddr = r_addr;
                    n_value   = r_rdata;
                end
                default: begin
                    n_value = r_rdata;
                end
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: if (r_clr_addr == AW'(MAX_CHANNELS - 1)) n_state = S_IDLE;
            S_IDLE:  if (accept) n_state = S_MAP;
            S_MAP:   n_state = S_MOD;
            S_MOD:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= mem[n_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_offset    <= ebin_pkg::OFFSET_RST;
            r_gain      <= ebin_pkg::GAIN_RST;
            r_count     <= ebin_pkg::COUNT_RST;
            o_valid     <= 1'b0;
            o_status    <= 1'b0;
            o_channel   <= '0;
            o_bin_value <= '0;
        end else begin
            r_state <= n_state;
            o_valid <= 1'b0;
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            if (cfg_write) begin
                case (paddr[ebin_pkg::APB_ADDR_W-1:2])
                    ebin_pkg::REG_OFFSET: r_offset <= pwdata[ebin_pkg::OFFSET_W-1:0];
                    ebin_pkg::REG_GAIN:   r_gain   <= pwdata;
                    ebin_pkg::REG_COUNT:  r_count  <= pwdata[ebin_pkg::COUNT_W-1:0];
                    default: ;
                endcase
            end
            if (accept) begin
                r_func   <= i_func;
                r_weight <= i_weight;
                r_index  <= i_bin_index;
                r_prod   <= n_prod;
            end
            if (r_state == S_MAP) begin
                r_ok   <= n_ok;
                r_chan <= n_chan;
                r_addr <= n_addr;
            end
            if (r_state == S_MOD) begin
                o_valid     <= 1'b1;
                o_status    <= !r_ok;
                o_channel   <= r_chan;
                o_bin_value <= n_value;
            end
        end
    end

    `CHK_NEXT(a_valid_single, o_valid, !o_valid)
    `CHK_NEXT(a_accept_busy, accept, busy && !o_valid)
    `CHK_SAME(a_no_result_in_clear, r_state == S_CLEAR, !o_valid)
    `CHK_SAME(a_error_zero_value, o_valid && o_status, o_bin_value == '0)
    `CHK_SAME(a_write_only_busy, mem_we, busy)

endmodule

`default_nettype wire

@@ test/tb_energy_histogram_binner.sv @@
// self-checking testbench for energy_histogram_binner: directed and random
// histogram commands checked against a local bin-store model; uses ebin_pkg only
`timescale 1ns / 100ps

module tb_energy_histogram_binner;

    localparam int          NUM_BINS     = ebin_pkg::DEF_MAX_CHANNELS;
    localparam int          STALL_LIMIT  = 20000;
    localparam int          PHASE_ITEMS  = 212;
    localparam logic [ebin_pkg::FUNC_W-1:0] FUNC_SPARE = 2'd3;

    typedef struct {
        logic [ebin_pkg::FUNC_W-1:0]   func;
        logic [ebin_pkg::ENERGY_W-1:0] energy;
        logic [ebin_pkg::WEIGHT_W-1:0] weight;
        logic [ebin_pkg::INDEX_W-1:0]  index;
        bit                            drain;
    } t_bin_cmd;

    typedef struct {
        logic                        status;
        logic [ebin_pkg::CHAN_W-1:0] channel;
        logic [ebin_pkg::BIN_W-1:0]  value;
    } t_bin_report;

    logic                            i_clk       = 1'b0;
    logic                            i_rst_n     = 1'b0;
    logic                            start       = 1'b0;
    logic [ebin_pkg::FUNC_W-1:0]     i_func      = '0;
    logic [ebin_pkg::ENERGY_W-1:0]   i_energy    = '0;
    logic [ebin_pkg::WEIGHT_W-1:0]   i_weight    = '0;
    logic [ebin_pkg::INDEX_W-1:0]    i_bin_index = '0;
    logic                            psel        = 1'b0;
    logic                            penable     = 1'b0;
    logic                            pwrite      = 1'b0;
    logic [ebin_pkg::APB_ADDR_W-1:0] paddr       = '0;
    logic [ebin_pkg::APB_DATA_W-1:0] pwdata      = '0;
    logic                            busy;
    logic                            o_valid;
    logic                            o_status;
    logic [ebin_pkg::CHAN_W-1:0]     o_channel;
    logic [ebin_pkg::BIN_W-1:0]      o_bin_value;
    logic [ebin_pkg::APB_DATA_W-1:0] prdata;
    logic                            pready;

    energy_histogram_binner dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_func      (i_func),
        .i_energy    (i_energy),
        .i_weight    (i_weight),
        .i_bin_index (i_bin_index),
        .o_valid     (o_valid),
        .o_status    (o_status),
        .o_channel   (o_channel),
        .o_bin_value (o_bin_value),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // local copy of the register file and the bin store
    logic signed [ebin_pkg::OFFSET_W-1:0] cfg_offset = ebin_pkg::OFFSET_RST;
    logic [ebin_pkg::GAIN_W-1:0]          cfg_gain   = ebin_pkg::GAIN_RST;
    logic [ebin_pkg::COUNT_W-1:0]         cfg_count  = ebin_pkg::COUNT_RST;
    logic [ebin_pkg::BIN_W-1:0]           hist_model [NUM_BINS];

    t_bin_cmd    cmds_waiting[$];
    t_bin_report bin_reports_due[$];
    t_bin_cmd    cmd_on_port;
    bit          cmd_live        = 1'b0;
    int unsigned sender_gap_pct  = 6;
    int unsigned fail_count      = 0;
    int unsigned stall_cycles    = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint active_bins();
        return (cfg_count > NUM_BINS) ? longint'(NUM_BINS) : longint'(cfg_count);
    endfunction

    // applies one command to the bin-store model and returns its report
    function automatic t_bin_report histogram_apply(t_bin_cmd c);
        t_bin_report             r;
        longint                  lim;
        longint                  diff;
        longint                  scaled;
        longint                  ch;
        logic [ebin_pkg::BIN_W:0] sum;
        lim = active_bins();
        r.status  = 1'b1;
        r.channel = '0;
        r.value   = '0;
        case (c.func)
            ebin_pkg::FUNC_ADD: begin
                diff   = longint'(c.energy) - longint'(cfg_offset);
                scaled = diff * longint'(cfg_gain) +
                         (longint'(1) << (ebin_pkg::FRAC_BITS - 1));
                if (scaled >= 0) begin
                    ch = scaled >>> ebin_pkg::FRAC_BITS;
                    if (ch < lim) begin
                        sum = {1'b0, hist_model[ch[ebin_pkg::INDEX_W-1:0]]} +
                              (ebin_pkg::BIN_W + 1)'(c.weight);
                        if (sum > {1'b0, ebin_pkg::BIN_MAX})
                            sum = {1'b0, ebin_pkg::BIN_MAX};
                        hist_model[ch[ebin_pkg::INDEX_W-1:0]] = sum[ebin_pkg::BIN_W-1:0];
                        r.status  = 1'b0;
                        r.channel = ch[ebin_pkg::CHAN_W-1:0];
                        r.value   = sum[ebin_pkg::BIN_W-1:0];
                    end
                end
            end
            ebin_pkg::FUNC_READ, ebin_pkg::FUNC_RCLR: begin
                r.channel = c.index;
                if (longint'(c.index) < lim) begin
                    r.status = 1'b0;
                    r.value  = hist_model[c.index];
                    if (c.func == ebin_pkg::FUNC_RCLR)
                        hist_model[c.index] = '0;
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    // driver: holds start until the beat is taken, then pulls the next command
    always @(posedge i_clk) begin : drive_cmds
        bit hold;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                bin_reports_due.push_back(histogram_apply(cmd_on_port));
                cmd_live = 1'b0;
            end
            if (!cmd_live && cmds_waiting.size() != 0) begin
                hold = ($urandom_range(0, 99) < sender_gap_pct) ||
                       (cmds_waiting[0].drain && bin_reports_due.size() != 0);
                if (!hold) begin
                    cmd_on_port = cmds_waiting.pop_front();
                    cmd_live    = 1'b1;
                end
            end
            start       <= cmd_live;
            i_func      <= cmd_on_port.func;
            i_energy    <= cmd_on_port.energy;
            i_weight    <= cmd_on_port.weight;
            i_bin_index <= cmd_on_port.index;
        end
    end

    // monitor: every result beat is checked against the oldest pending report
    always @(posedge i_clk) begin : check_reports
        t_bin_report exp_rep;
        if (i_rst_n && o_valid) begin
            if (bin_reports_due.size() == 0) begin
                $error("result beat with nothing pending: channel %0d value %0d",
                       o_channel, o_bin_value);
                fail_count++;
            end else begin
                exp_rep = bin_reports_due.pop_front();
                if (o_status !== exp_rep.status) begin
                    $error("status: expected %0d, got %0d", exp_rep.status, o_status);
                    fail_count++;
                end
                if (o_channel !== exp_rep.channel) begin
                    $error("channel: expected %0d, got %0d", exp_rep.channel, o_channel);
                    fail_count++;
                end
                if (o_bin_value !== exp_rep.value) begin
                    $error("bin_value: expected %0d, got %0d", exp_rep.value, o_bin_value);
                    fail_count++;
                end
            end
        end
    end

    // watchdog on cycles without an accepted beat, a result beat or a register access
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid === 1'b1 || psel)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic write_reg(ebin_pkg::t_reg_sel sel,
                             logic [ebin_pkg::APB_DATA_W-1:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ebin_pkg::APB_ADDR_W'(sel) << 2;
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (sel)
            ebin_pkg::REG_OFFSET: cfg_offset = val[ebin_pkg::OFFSET_W-1:0];
            ebin_pkg::REG_GAIN:   cfg_gain   = val[ebin_pkg::GAIN_W-1:0];
            ebin_pkg::REG_COUNT:  cfg_count  = val[ebin_pkg::COUNT_W-1:0];
            default: begin
            end
        endcase
    endtask

    task automatic set_config(int offset, logic [ebin_pkg::GAIN_W-1:0] gain,
                              int unsigned count);
        write_reg(ebin_pkg::REG_OFFSET, ebin_pkg::APB_DATA_W'(offset));
        write_reg(ebin_pkg::REG_GAIN, gain);
        write_reg(ebin_pkg::REG_COUNT, ebin_pkg::APB_DATA_W'(count));
    endtask

    // waits until every command went out and every report came back
    task automatic wait_idle();
        @(negedge i_clk);
        while (cmds_waiting.size() != 0 || cmd_live || bin_reports_due.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic queue_cmd(logic [ebin_pkg::FUNC_W-1:0] func, int unsigned energy,
                             int unsigned weight, int unsigned index);
        t_bin_cmd c;
        c.func   = func;
        c.energy = energy[ebin_pkg::ENERGY_W-1:0];
        c.weight = weight[ebin_pkg::WEIGHT_W-1:0];
        c.index  = index[ebin_pkg::INDEX_W-1:0];
        c.drain  = 1'b0;
        cmds_waiting.push_back(c);
    endtask

    // mostly adds aimed into the active channel range, plus reads and noise
    function automatic t_bin_cmd random_cmd();
        t_bin_cmd    c;
        longint      lim;
        longint      span;
        longint      e;
        int unsigned pick;
        lim      = active_bins();
        c.func   = ebin_pkg::FUNC_ADD;
        c.energy = ebin_pkg::ENERGY_W'($urandom);
        c.weight = ebin_pkg::WEIGHT_W'($urandom);
        c.index  = ebin_pkg::INDEX_W'($urandom);
        c.drain  = ($urandom_range(0, 99) == 0);
        pick     = $urandom_range(0, 99);
        if (pick < 60) begin
            if (cfg_gain == 0)
                span = longint'(1) << ebin_pkg::ENERGY_W;
            else
                span = ((lim << ebin_pkg::FRAC_BITS) + longint'(cfg_gain)) /
                       longint'(cfg_gain);
            if (span > (longint'(1) << (ebin_pkg::ENERGY_W + 1)))
                span = longint'(1) << (ebin_pkg::ENERGY_W + 1);
            e = longint'(cfg_offset) + longint'($urandom_range(0, int'(span)));
            if (e < 0)
                e = 0;
            if (e >= (longint'(1) << ebin_pkg::ENERGY_W))
                e = (longint'(1) << ebin_pkg::ENERGY_W) - 1;
            c.energy = e[ebin_pkg::ENERGY_W-1:0];
            if ($urandom_range(0, 9) == 0)
                c.weight = '1;
        end else if (pick < 97 && pick >= 75) begin
            c.func = (pick < 86) ? ebin_pkg::FUNC_READ : ebin_pkg::FUNC_RCLR;
            if (lim > 0 && $urandom_range(0, 1) == 1)
                c.index = ebin_pkg::INDEX_W'($urandom_range(0, int'(lim) - 1));
        end else if (pick >= 97) begin
            c.func = FUNC_SPARE;
        end
        return c;
    endfunction

    initial begin : stimulus
        int ph;
        foreach (hist_model[i])
            hist_model[i] = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: corners of the channel range and read paths
        queue_cmd(ebin_pkg::FUNC_ADD, 0, 0, 0);
        queue_cmd(ebin_pkg::FUNC_ADD, 0, 16'hFFFF, 0);
        queue_cmd(ebin_pkg::FUNC_ADD, 4095, 1, 0);
        queue_cmd(ebin_pkg::FUNC_ADD, 4096, 5, 0);
        queue_cmd(ebin_pkg::FUNC_ADD, 20'hFFFFF, 16'hFFFF, 12'hFFF);
        queue_cmd(ebin_pkg::FUNC_ADD, 7, 16'h1234, 0);
        queue_cmd(ebin_pkg::FUNC_ADD, 7, 16'h1234, 0);
        queue_cmd(ebin_pkg::FUNC_READ, 0, 0, 0);
        queue_cmd(ebin_pkg::FUNC_READ, 0, 0, 4095);
        queue_cmd(ebin_pkg::FUNC_RCLR, 0, 0, 7);
        queue_cmd(ebin_pkg::FUNC_READ, 0, 0, 7);
        queue_cmd(ebin_pkg::FUNC_RCLR, 20'hFFFFF, 16'hFFFF, 4095);
        queue_cmd(ebin_pkg::FUNC_READ, 0, 0, 100);
        queue_cmd(FUNC_SPARE, 20'hFFFFF, 16'hFFFF, 12'hFFF);
        wait_idle();

        // half gain, small count: rounding at minus one half, below zero, top edge
        set_config(16, ebin_pkg::GAIN_W'(1) << 23, 8);
        queue_cmd(ebin_pkg::FUNC_ADD, 15, 3, 0);
        queue_cmd(ebin_pkg::FUNC_ADD, 14, 3, 0);
        queue_cmd(ebin_pkg::FUNC_ADD, 17, 3, 0);
        queue_cmd(ebin_pkg::FUNC_ADD, 30, 3, 0);
        queue_cmd(ebin_pkg::FUNC_ADD, 31, 3, 0);
        queue_cmd(ebin_pkg::FUNC_READ, 0, 0, 8);
        queue_cmd(ebin_pkg::FUNC_RCLR, 0, 0, 9);
        queue_cmd(ebin_pkg::FUNC_READ, 0, 0, 4095);
        wait_idle();

        // zero channels in use: everything out of range
        set_config(0, ebin_pkg::GAIN_RST, 0);
        queue_cmd(ebin_pkg::FUNC_ADD, 0, 1, 0);
        queue_cmd(ebin_pkg::FUNC_READ, 0, 0, 0);
        queue_cmd(ebin_pkg::FUNC_RCLR, 0, 0, 0);
        wait_idle();

        for (ph = 0; ph < 8; ph++) begin
            case (ph)
                0: set_config(-1048576, 32'd32768, 4096);
                1: set_config(1048575, 32'hFFFF_FFFF, 1);
                2: set_config($urandom_range(0, 524288), 32'd0, 8191);
                3: set_config(0, ebin_pkg::GAIN_RST, 4096);
                4: set_config($urandom_range(0, 4000), $urandom_range(1 << 20, 1 << 28),
                              $urandom_range(1, 4096));
                5: set_config(1000, 32'd3 << ebin_pkg::FRAC_BITS, 100);
                6: set_config($urandom, $urandom, $urandom_range(0, 8191));
                default: set_config(-5000, ebin_pkg::GAIN_W'(1) << 22, 4096);
            endcase
            sender_gap_pct = (ph < 3) ? 6 : (ph < 6) ? 69 : 0;
            repeat (PHASE_ITEMS)
                cmds_waiting.push_back(random_cmd());
            wait_idle();
        end

        repeat (10) @(posedge i_clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
